// ----- hw/rtl/mmix_pkg.sv -----
package mmix_pkg;

  // Motor lanes and register map
  localparam int MOTOR_COUNT_DEFAULT = 4;
  localparam int SCALED_MOTORS       = 4;
  localparam int CFG_IDX_W           = 3;
  localparam int CFG_DATA_W          = 48;

  localparam logic [CFG_IDX_W-1:0] REG_MOTOR0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUM_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THR_MARK  = 3'd5;

  // Field widths
  localparam int AXIS_W   = 16;
  localparam int THR_IN_W = 14;
  localparam int DUTY_W   = 14;
  localparam int SCALE_W  = 16;
  localparam int SCALES_W = 3 * SCALE_W;
  localparam int LIMIT_W  = 15;
  localparam int MARK_W   = 14;

  localparam logic [LIMIT_W-1:0] SUM_LIMIT_RESET = 15'd500;
  localparam logic [MARK_W-1:0]  THR_MARK_RESET  = 14'd5000;

  // Q16 fixed point
  localparam int Q_FRAC = 16;
  localparam int Q_ONE  = 1 << Q_FRAC;

  // Axis sum to Q16: (|s| * 2^16 + 500) / 1000 by reciprocal multiply
  localparam int AXIS_X_W   = LIMIT_W + Q_FRAC;
  localparam int RECIP_W    = 31;
  localparam int AXIS_P_W   = AXIS_X_W + RECIP_W;
  localparam int AXIS_SHIFT = 40;
  localparam int AXIS_Q_W   = 22;
  localparam int AXIS_V_W   = AXIS_Q_W + 1;
  localparam int AXIS_DIV   = 1000;
  localparam int AXIS_BIAS  = 500;
  localparam logic [RECIP_W-1:0] AXIS_RECIP = 31'd1099511627;

  // Throttle to Q16: (t * 2^16 + 5000) / 10000 by reciprocal multiply
  localparam int THR_X_W   = THR_IN_W + Q_FRAC;
  localparam int THR_P_W   = THR_X_W + RECIP_W;
  localparam int THR_SHIFT = 44;
  localparam int THR_Q_W   = 17;
  localparam int THR_DIV   = 10000;
  localparam int THR_BIAS  = 5000;
  localparam logic [RECIP_W-1:0] THR_RECIP = 31'd1759218604;

  // Mix arithmetic
  localparam int PROD_W   = AXIS_V_W + SCALE_W;
  localparam int ACC_W    = PROD_W + 1;
  localparam int MIX_DROP = 14;
  localparam int MIX_HALF = 1 << (MIX_DROP - 1);
  localparam int MIX_W    = ACC_W - MIX_DROP;
  localparam int RANGE_W  = MIX_W + 1;
  localparam int THR_W    = MIX_W + 2;
  localparam int QUO_W    = Q_FRAC + 1;
  localparam int SUM_W    = MIX_W + 3;

  // Duty conversion
  localparam int DUTY_STEP = 100;
  localparam int PCT_MAX   = 100;
  localparam int PCT_W     = 7;
  localparam int DUTY_MAX  = 10000;

  typedef struct packed {
    logic signed [AXIS_W-1:0] roll_sum;
    logic signed [AXIS_W-1:0] pitch_sum;
    logic signed [AXIS_W-1:0] yaw_sum;
    logic [THR_IN_W-1:0]      throttle;
  } sample_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_0;
    logic [DUTY_W-1:0] duty_1;
    logic [DUTY_W-1:0] duty_2;
    logic [DUTY_W-1:0] duty_3;
  } duty_set_t;

  // One range division: magnitude of a mix value, its sign, the range
  typedef struct packed {
    logic [MIX_W-1:0]   mag;
    logic               sgn;
    logic [RANGE_W-1:0] divisor;
  } div_op_t;

endpackage

// ----- hw/rtl/mmix_div_lane.sv -----
module mmix_div_lane (
  input  logic                             clk,
  input  mmix_pkg::div_op_t                op,
  output logic signed [mmix_pkg::QUO_W:0]  quo
);
  import mmix_pkg::*;

  // One quotient bit per stage, most significant first: mag * 2^16 / divisor
  localparam int STAGES = QUO_W;
  localparam int PRE_W  = RANGE_W + 1;

  logic [RANGE_W-1:0] rem [STAGES-1];
  logic [RANGE_W-1:0] dvs [STAGES-1];
  logic [QUO_W-1:0]   qb  [STAGES];
  logic               sg  [STAGES];

  logic [PRE_W-1:0]   pre   [STAGES];
  logic [PRE_W-1:0]   dv_in [STAGES];
  logic [PRE_W-1:0]   diff  [STAGES];
  logic               take  [STAGES];
  logic signed [QUO_W:0] q_s;

  always_comb begin
    pre[0]   = PRE_W'(op.mag);
    dv_in[0] = PRE_W'(op.divisor);
    for (int i = 1; i < STAGES; i++) begin
      pre[i]   = {rem[i-1], 1'b0};
      dv_in[i] = PRE_W'(dvs[i-1]);
    end
    for (int i = 0; i < STAGES; i++) begin
      diff[i] = pre[i] - dv_in[i];
      take[i] = pre[i] >= dv_in[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < STAGES - 1; i++) begin
      rem[i] <= take[i] ? diff[i][RANGE_W-1:0] : pre[i][RANGE_W-1:0];
      dvs[i] <= dv_in[i][RANGE_W-1:0];
    end
    qb[0] <= QUO_W'(take[0]);
    sg[0] <= op.sgn;
    for (int i = 1; i < STAGES; i++) begin
      qb[i] <= {qb[i-1][QUO_W-2:0], take[i]};
      sg[i] <= sg[i-1];
    end
  end

  // Truncate toward zero: divide the magnitude, restore the sign
  assign q_s = signed'({1'b0, qb[STAGES-1]});
  assign quo = sg[STAGES-1] ? -q_s : q_s;

endmodule

// ----- hw/rtl/multirotor_motor_mixer_core.sv -----
// Channel   Ports                          Handshake
// --------  -----------------------------  ---------------------------------------
// sample    start, busy, sample            transaction at edge with start & !busy
// result    done, result                   one-cycle strobe, receiver cannot stall
// config    cfg_we, cfg_idx, cfg_wdata     write at edge with cfg_we, no read-back
//
// One sample enters every cycle; busy is always low. From the accepting edge to the
// cycle in which done is high a sample passes 8 stages of scaling, mixing and
// min/max, 17 stages of the bit-per-stage range divider, 2 stages of throttle add
// and duty conversion. Synchronous reset clears every valid bit and loads the
// register reset values; there is no clearing pass. The pipeline never stalls,
// so no transaction is held, lost or repeated.
module multirotor_motor_mixer_core #(
  parameter int MOTOR_COUNT = mmix_pkg::MOTOR_COUNT_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  mmix_pkg::sample_t                 sample,
  output logic                              done,
  output mmix_pkg::duty_set_t               result,
  input  logic                              cfg_we,
  input  logic [mmix_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [mmix_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import mmix_pkg::*;

  localparam int PRE_STAGES = 8;
  localparam int DIV_STAGES = QUO_W;
  localparam int LATENCY    = PRE_STAGES + DIV_STAGES + 2;
  localparam int OUT_MOTORS = 4;
  localparam int P100_W     = SUM_W + 7;
  localparam int PCT_FULL_W = P100_W - Q_FRAC;

  // Clamp an axis sum to +/-lim; return {negative, magnitude}
  function automatic logic [LIMIT_W:0] axis_clamp(logic signed [AXIS_W-1:0] s,
                                                  logic [LIMIT_W-1:0] lim);
    logic signed [AXIS_W:0] se;
    logic signed [AXIS_W:0] lm;
    logic signed [AXIS_W:0] c;
    logic signed [AXIS_W:0] mag;
    se = (AXIS_W+1)'(s);
    lm = signed'((AXIS_W+1)'(lim));
    if (se > lm) begin
      c = lm;
    end else if (se < -lm) begin
      c = -lm;
    end else begin
      c = se;
    end
    mag = c[AXIS_W] ? -c : c;
    return {c[AXIS_W], mag[LIMIT_W-1:0]};
  endfunction

  // The mixer takes a sample every cycle
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Configuration registers; scale registers are writable for the first four motors,
  // any further lanes keep zero scales
  // ---------------------------------------------------------------------------
  logic [SCALES_W-1:0] scales [MOTOR_COUNT];
  logic [LIMIT_W-1:0]  sum_limit;
  logic [MARK_W-1:0]   thr_mark;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MOTOR_COUNT; k++) begin
        scales[k] <= '0;
      end
      sum_limit <= SUM_LIMIT_RESET;
      thr_mark  <= THR_MARK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SUM_LIMIT: sum_limit <= cfg_wdata[LIMIT_W-1:0];
        REG_THR_MARK:  thr_mark  <= cfg_wdata[MARK_W-1:0];
        default: begin
          for (int k = 0; k < MOTOR_COUNT; k++) begin
            if (k < SCALED_MOTORS && cfg_idx == CFG_IDX_W'(int'(REG_MOTOR0) + k)) begin
              scales[k] <= cfg_wdata[SCALES_W-1:0];
            end
          end
        end
      endcase
    end
  end

  // Valid bits of the front stages, s0 .. s7
  logic [PRE_STAGES-1:0] pv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else begin
      pv <= {pv[PRE_STAGES-2:0], start & ~busy};
    end
  end

  // ---------------------------------------------------------------------------
  // s0: capture the accepted sample
  // ---------------------------------------------------------------------------
  sample_t s0;

  always_ff @(posedge clk) begin
    s0 <= sample;
  end

  // ---------------------------------------------------------------------------
  // s1: clamp each axis, form the scaled numerators; compare throttle to mark
  // ---------------------------------------------------------------------------
  logic signed [AXIS_W-1:0] ax_in [3];
  logic [LIMIT_W:0]         ax_cl [3];
  logic [AXIS_X_W-1:0]      ax_x1 [3];
  logic                     ax_n1 [3];
  logic [THR_X_W-1:0]       th_x1;
  logic                     hot1;

  assign ax_in[0] = s0.roll_sum;
  assign ax_in[1] = s0.pitch_sum;
  assign ax_in[2] = s0.yaw_sum;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ax_cl[a] = axis_clamp(ax_in[a], sum_limit);
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      ax_n1[a] <= ax_cl[a][LIMIT_W];
      ax_x1[a] <= {ax_cl[a][LIMIT_W-1:0], {Q_FRAC{1'b0}}} + AXIS_X_W'(AXIS_BIAS);
    end
    th_x1 <= {s0.throttle, {Q_FRAC{1'b0}}} + THR_X_W'(THR_BIAS);
    hot1  <= s0.throttle > thr_mark;
  end

  // ---------------------------------------------------------------------------
  // s2: reciprocal multiply, quotient estimate one short at most
  // ---------------------------------------------------------------------------
  logic [AXIS_P_W-1:0] ax_p  [3];
  logic [THR_P_W-1:0]  th_p;
  logic [AXIS_Q_W-1:0] ax_qe2 [3];
  logic [AXIS_X_W-1:0] ax_x2  [3];
  logic                ax_n2  [3];
  logic [THR_Q_W-1:0]  th_qe2;
  logic [THR_X_W-1:0]  th_x2;
  logic                hot2;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ax_p[a] = ax_x1[a] * AXIS_RECIP;
    end
    th_p = th_x1 * THR_RECIP;
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      ax_qe2[a] <= ax_p[a][AXIS_SHIFT +: AXIS_Q_W];
      ax_x2[a]  <= ax_x1[a];
      ax_n2[a]  <= ax_n1[a];
    end
    th_qe2 <= th_p[THR_SHIFT +: THR_Q_W];
    th_x2  <= th_x1;
    hot2   <= hot1;
  end

  // ---------------------------------------------------------------------------
  // s3: correct the estimate by one, apply the axis sign
  // ---------------------------------------------------------------------------
  logic [AXIS_X_W-1:0]        ax_m [3];
  logic [AXIS_X_W-1:0]        ax_r [3];
  logic [AXIS_Q_W-1:0]        ax_q [3];
  logic signed [AXIS_V_W-1:0] ax_qs [3];
  logic signed [AXIS_V_W-1:0] ax_v3 [3];
  logic [THR_X_W-1:0]         th_m;
  logic [THR_X_W-1:0]         th_r;
  logic [THR_Q_W-1:0]         th_q3;
  logic                       hot3;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ax_m[a]  = ax_qe2[a] * AXIS_X_W'(AXIS_DIV);
      ax_r[a]  = ax_x2[a] - ax_m[a];
      ax_q[a]  = ax_qe2[a] + AXIS_Q_W'(ax_r[a] >= AXIS_X_W'(AXIS_DIV));
      ax_qs[a] = signed'({1'b0, ax_q[a]});
    end
    th_m = th_qe2 * THR_X_W'(THR_DIV);
    th_r = th_x2 - th_m;
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      ax_v3[a] <= ax_n2[a] ? -ax_qs[a] : ax_qs[a];
    end
    th_q3 <= th_qe2 + THR_Q_W'(th_r >= THR_X_W'(THR_DIV));
    hot3  <= hot2;
  end

  // ---------------------------------------------------------------------------
  // s4: axis times per-motor scale, three products per lane
  // ---------------------------------------------------------------------------
  logic signed [SCALE_W-1:0] sc   [MOTOR_COUNT][3];
  logic signed [PROD_W-1:0]  pr4  [MOTOR_COUNT][3];
  logic [THR_Q_W-1:0]        th_q4;
  logic                      hot4;

  always_comb begin
    for (int k = 0; k < MOTOR_COUNT; k++) begin
      for (int a = 0; a < 3; a++) begin
        sc[k][a] = signed'(scales[k][a*SCALE_W +: SCALE_W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MOTOR_COUNT; k++) begin
      for (int a = 0; a < 3; a++) begin
        pr4[k][a] <= ax_v3[a] * sc[k][a];
      end
    end
    th_q4 <= th_q3;
    hot4  <= hot3;
  end

  // ---------------------------------------------------------------------------
  // s5: sum the products and round to Q16 (add half, floor)
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] acc [MOTOR_COUNT];
  logic signed [MIX_W-1:0] mix5 [MOTOR_COUNT];
  logic [THR_Q_W-1:0]      th_q5;
  logic                    hot5;

  always_comb begin
    for (int k = 0; k < MOTOR_COUNT; k++) begin
      acc[k] = ACC_W'(pr4[k][0]) + ACC_W'(pr4[k][1]) + ACC_W'(pr4[k][2])
             + ACC_W'(MIX_HALF);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MOTOR_COUNT; k++) begin
      mix5[k] <= acc[k][ACC_W-1:MIX_DROP];
    end
    th_q5 <= th_q4;
    hot5  <= hot4;
  end

  // ---------------------------------------------------------------------------
  // s6: minimum and maximum over the lanes, both seeded with zero
  // ---------------------------------------------------------------------------
  logic signed [MIX_W-1:0] mn_c;
  logic signed [MIX_W-1:0] mx_c;
  logic signed [MIX_W-1:0] mn6;
  logic signed [MIX_W-1:0] mx6;
  logic signed [MIX_W-1:0] mix6 [MOTOR_COUNT];
  logic [THR_Q_W-1:0]      th_q6;
  logic                    hot6;

  always_comb begin
    mn_c = '0;
    mx_c = '0;
    for (int k = 0; k < MOTOR_COUNT; k++) begin
      if (mix5[k] < mn_c) begin
        mn_c = mix5[k];
      end
      if (mix5[k] > mx_c) begin
        mx_c = mix5[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    mn6   <= mn_c;
    mx6   <= mx_c;
    mix6  <= mix5;
    th_q6 <= th_q5;
    hot6  <= hot5;
  end

  // ---------------------------------------------------------------------------
  // s7: range, divide decision, throttle headroom clamp, divider operands
  // ---------------------------------------------------------------------------
  logic signed [RANGE_W-1:0] rg_c;
  logic signed [RANGE_W-1:0] lo_c;
  logic signed [RANGE_W-1:0] hi_c;
  logic signed [THR_W-1:0]   thr_raw;
  logic signed [THR_W-1:0]   thr_c;
  logic                      big_c;
  logic signed [MIX_W-1:0]   mag_c [MOTOR_COUNT];

  logic                      big7;
  logic signed [THR_W-1:0]   thr7;
  logic signed [MIX_W-1:0]   mix7 [MOTOR_COUNT];
  div_op_t                   dop7 [MOTOR_COUNT];

  always_comb begin
    rg_c    = RANGE_W'(mx6) - RANGE_W'(mn6);
    big_c   = rg_c > RANGE_W'(Q_ONE);
    lo_c    = -RANGE_W'(mn6);
    hi_c    = RANGE_W'(Q_ONE) - RANGE_W'(mx6);
    thr_raw = signed'(THR_W'(th_q6));
    thr_c   = thr_raw;
    // Keep every motor inside 0..1 when the mix leaves headroom and the throttle is above the mark
    if (!big_c && hot6) begin
      if (thr_raw < THR_W'(lo_c)) begin
        thr_c = THR_W'(lo_c);
      end else if (thr_raw > THR_W'(hi_c)) begin
        thr_c = THR_W'(hi_c);
      end
    end
    for (int k = 0; k < MOTOR_COUNT; k++) begin
      mag_c[k] = mix6[k][MIX_W-1] ? -mix6[k] : mix6[k];
    end
  end

  always_ff @(posedge clk) begin
    big7 <= big_c;
    thr7 <= thr_c;
    mix7 <= mix6;
    for (int k = 0; k < MOTOR_COUNT; k++) begin
      dop7[k].mag     <= mag_c[k];
      dop7[k].sgn     <= mix6[k][MIX_W-1];
      dop7[k].divisor <= rg_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Range divider lanes; the undivided mix, throttle, divide flag and valid bits ride
  // alongside for the same number of stages
  // ---------------------------------------------------------------------------
  logic signed [QUO_W:0]   quo [MOTOR_COUNT];
  logic [DIV_STAGES-1:0]   dv_v;
  logic [DIV_STAGES-1:0]   dv_big;
  logic signed [THR_W-1:0] dv_thr [DIV_STAGES];
  logic signed [MIX_W-1:0] dv_mix [DIV_STAGES][MOTOR_COUNT];

  for (genvar k = 0; k < MOTOR_COUNT; k++) begin : g_lane
    mmix_div_lane u_div (
      .clk (clk),
      .op  (dop7[k]),
      .quo (quo[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v <= '0;
    end else begin
      dv_v <= {dv_v[DIV_STAGES-2:0], pv[PRE_STAGES-1]};
    end
    dv_big    <= {dv_big[DIV_STAGES-2:0], big7};
    dv_thr[0] <= thr7;
    dv_mix[0] <= mix7;
    for (int i = 1; i < DIV_STAGES; i++) begin
      dv_thr[i] <= dv_thr[i-1];
      dv_mix[i] <= dv_mix[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Add throttle to the (possibly divided) mix
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] mix_f [MOTOR_COUNT];
  logic signed [SUM_W-1:0] sm [MOTOR_COUNT];
  logic                    sm_v;

  always_comb begin
    for (int k = 0; k < MOTOR_COUNT; k++) begin
      mix_f[k] = dv_big[DIV_STAGES-1] ? SUM_W'(quo[k])
                                      : SUM_W'(dv_mix[DIV_STAGES-1][k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sm_v <= 1'b0;
    end else begin
      sm_v <= dv_v[DIV_STAGES-1];
    end
    for (int k = 0; k < MOTOR_COUNT; k++) begin
      sm[k] <= mix_f[k] + SUM_W'(dv_thr[DIV_STAGES-1]);
    end
  end

  // ---------------------------------------------------------------------------
  // Whole percent, times 100, clamp to 0..10000; non-positive sums give 0
  // ---------------------------------------------------------------------------
  logic signed [P100_W-1:0]  p100 [MOTOR_COUNT];
  logic [PCT_FULL_W-1:0]     pct  [MOTOR_COUNT];
  logic [DUTY_W-1:0]         duty_c [MOTOR_COUNT];
  logic [DUTY_W-1:0]         duty_r [MOTOR_COUNT];
  logic [DUTY_W-1:0]         duty_vec [OUT_MOTORS];

  always_comb begin
    for (int k = 0; k < MOTOR_COUNT; k++) begin
      p100[k] = sm[k] * P100_W'(DUTY_STEP);
      pct[k]  = p100[k][P100_W-1:Q_FRAC];
      if (sm[k] <= 0) begin
        duty_c[k] = '0;
      end else if (pct[k] > PCT_FULL_W'(PCT_MAX)) begin
        duty_c[k] = DUTY_W'(DUTY_MAX);
      end else begin
        duty_c[k] = DUTY_W'(pct[k][PCT_W-1:0]) * DUTY_W'(DUTY_STEP);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sm_v;
    end
    duty_r <= duty_c;
  end

  // Motors beyond the lane count report zero
  for (genvar k = 0; k < OUT_MOTORS; k++) begin : g_out
    if (k < MOTOR_COUNT) begin : g_used
      assign duty_vec[k] = duty_r[k];
    end else begin : g_unused
      assign duty_vec[k] = '0;
    end
  end

  assign result = '{duty_0: duty_vec[0], duty_1: duty_vec[1],
                    duty_2: duty_vec[2], duty_3: duty_vec[3]};

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  logic mags_ok;
  logic quo_ok;

  always_comb begin
    mags_ok = 1'b1;
    quo_ok  = 1'b1;
    for (int k = 0; k < MOTOR_COUNT; k++) begin
      if (RANGE_W'(dop7[k].mag) > dop7[k].divisor) begin
        mags_ok = 1'b0;
      end
      if (quo[k] > (QUO_W+1)'(Q_ONE) || quo[k] < -(QUO_W+1)'(Q_ONE)) begin
        quo_ok = 1'b0;
      end
    end
  end

  // A result appears exactly the pipeline depth after an accepted sample
  a_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a sample accepted %0d cycles earlier", LATENCY);

  // Min/max seeding guarantees every mix magnitude is within the range
  a_div_in: assert property (@(posedge clk) disable iff (rst)
    (pv[PRE_STAGES-1] && big7) |-> mags_ok)
    else $error("divider operand exceeds the mix range");

  // A divided mix never exceeds one in Q16
  a_div_out: assert property (@(posedge clk) disable iff (rst)
    (dv_v[DIV_STAGES-1] && dv_big[DIV_STAGES-1]) |-> quo_ok)
    else $error("range divider quotient out of bounds");

endmodule
